// ----- design/tsa_pkg.sv -----
// Package for the typed slot allocator: word types, codes, controller states
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsa_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_ILLEGAL = 2'd3;

    localparam logic [1:0] KIND_INACTIVE = 2'd0;
    localparam logic [1:0] KIND_SMALL    = 2'd1;
    localparam logic [1:0] KIND_LARGE    = 2'd2;
    localparam logic [1:0] KIND_BAD      = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [1:0] ST_BAD_KIND = 2'd3;

    localparam logic [1:0] REG_FLOORS  = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_COLUMNS = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] floor_index;
        logic [9:0] row_index;
        logic [9:0] column_index;
        logic [1:0] slot_kind;
        logic       strategy;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  granted_floor;
        logic [9:0]  granted_row;
        logic [9:0]  granted_column;
        logic [10:0] free_small;
        logic [10:0] free_large;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_CHECK, S_READ, S_UPDATE,
        S_BEST, S_PICK, S_SCAN, S_GRANT, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        CNT_NONE, CNT_LOAD, CNT_REL, CNT_ALLOC
    } t_cnt_op;

    typedef struct packed {
        logic       capture;
        logic       prep;
        logic       clear;
        logic       set_st;
        logic [1:0] st_code;
        logic       wr_load;
        logic       wr_release;
        logic       wr_alloc;
        t_cnt_op    cnt_op;
        logic       best_start;
        logic       best_step;
        logic       scan_start;
        logic       scan_single;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] mode;
        logic [1:0] kind;
        logic       strategy;
        logic       exists;
        logic       slot_ok;
        logic       best_last;
        logic       best_zero;
        logic       scan_hit;
        logic       scan_miss;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- design/tsa_ctrl.sv -----
// Controller state machine of the typed slot allocator.
// Depends on tsa_pkg; drives tsa_datapath through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none
module tsa_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    output logic            o_busy,
    output logic            o_strobe,
    output tsa_pkg::t_dp_cmd o_cmd,
    input  tsa_pkg::t_dp_sts i_sts
);
    import tsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_PREP;
            S_PREP:   n_state = S_CHECK;
            S_CHECK: begin
                case (i_sts.mode)
                    MODE_LOAD:
                        n_state = (i_sts.kind == KIND_BAD || !i_sts.exists) ? S_RESP : S_READ;
                    MODE_ALLOC:
                        if (i_sts.kind != KIND_SMALL && i_sts.kind != KIND_LARGE)
                            n_state = S_RESP;
                        else
                            n_state = i_sts.strategy ? S_BEST : S_SCAN;
                    MODE_RELEASE:
                        n_state = i_sts.exists ? S_READ : S_RESP;
                    default: n_state = S_RESP;
                endcase
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_RESP;
            S_BEST:   if (i_sts.best_last) n_state = S_PICK;
            S_PICK:   n_state = i_sts.best_zero ? S_RESP : S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_hit)       n_state = S_GRANT;
                else if (i_sts.scan_miss) n_state = S_RESP;
            end
            S_GRANT:  n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = (r_state != S_IDLE);
        o_strobe = (r_state == S_RESP);
        unique case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE:  o_cmd.capture = i_start;
            S_PREP:  o_cmd.prep = 1'b1;
            S_CHECK: begin
                case (i_sts.mode)
                    MODE_LOAD: begin
                        if (i_sts.kind == KIND_BAD) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_BAD_KIND;
                        end else if (!i_sts.exists) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_BAD_SLOT;
                        end
                    end
                    MODE_ALLOC: begin
                        if (i_sts.kind != KIND_SMALL && i_sts.kind != KIND_LARGE) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_BAD_KIND;
                        end else if (i_sts.strategy) begin
                            o_cmd.best_start = 1'b1;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    MODE_RELEASE: begin
                        if (!i_sts.exists) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_BAD_SLOT;
                        end
                    end
                    default: begin
                        o_cmd.set_st  = 1'b1;
                        o_cmd.st_code = ST_BAD_SLOT;
                    end
                endcase
            end
            S_UPDATE: begin
                o_cmd.set_st = 1'b1;
                if (i_sts.mode == MODE_LOAD) begin
                    o_cmd.wr_load = 1'b1;
                    o_cmd.cnt_op  = CNT_LOAD;
                    o_cmd.st_code = ST_OK;
                end else if (i_sts.slot_ok) begin
                    o_cmd.wr_release = 1'b1;
                    o_cmd.cnt_op     = CNT_REL;
                    o_cmd.st_code    = ST_OK;
                end else begin
                    o_cmd.st_code = ST_BAD_SLOT;
                end
            end
            S_BEST: o_cmd.best_step = 1'b1;
            S_PICK: begin
                if (i_sts.best_zero) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_NO_FREE;
                end else begin
                    o_cmd.scan_start  = 1'b1;
                    o_cmd.scan_single = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_miss && !i_sts.scan_hit) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_NO_FREE;
                end
            end
            S_GRANT: begin
                o_cmd.wr_alloc = 1'b1;
                o_cmd.cnt_op   = CNT_ALLOC;
                o_cmd.set_st   = 1'b1;
                o_cmd.st_code  = ST_OK;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/tsa_datapath.sv -----
// Datapath of the typed slot allocator: slot memory, per-floor free counts,
// address arithmetic, the serial slot scan and the best-floor search.
// Depends on tsa_pkg; controlled by tsa_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module tsa_datapath #(
    parameter int MAX_FLOORS      = 8,
    parameter int SLOTS_PER_FLOOR = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tsa_pkg::t_in_word  i_item,
    input  wire [3:0]          i_floors,
    input  wire [10:0]         i_rows,
    input  wire [10:0]         i_cols,
    input  tsa_pkg::t_dp_cmd   i_cmd,
    output tsa_pkg::t_dp_sts   o_sts,
    output tsa_pkg::t_out_word o_result
);
    import tsa_pkg::*;

    localparam int DEPTH = MAX_FLOORS * SLOTS_PER_FLOOR;
    localparam int IW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SLOTS_PER_FLOOR + 1);
    localparam int CFW   = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam int FHI   = (MAX_FLOORS < 8) ? MAX_FLOORS : 8;

    function automatic logic [CFW-1:0] fidx(input logic [3:0] v);
        return v[CFW-1:0];
    endfunction

    function automatic logic [10:0] sat11(input logic [SW-1:0] v);
        if (32'(v) > 32'd2047) return 11'h7FF;
        return 11'(v);
    endfunction

    // Clamped geometry.
    logic [3:0]  nf;
    logic [10:0] rows_eff, cols_eff;
    always_comb begin
        if (i_floors == 4'd0)              nf = 4'd1;
        else if (32'(i_floors) > FHI)      nf = 4'(FHI);
        else                               nf = i_floors;
        if (i_rows == 11'd0)               rows_eff = 11'd1;
        else if (i_rows > 11'd1024)        rows_eff = 11'd1024;
        else                               rows_eff = i_rows;
        if (i_cols == 11'd0)               cols_eff = 11'd1;
        else if (i_cols > 11'd1024)        cols_eff = 11'd1024;
        else                               cols_eff = i_cols;
    end

    t_in_word        r_item;
    logic [SW-1:0]   r_span;
    logic [21:0]     r_off;
    logic [IW-1:0]   r_idx;
    logic [1:0]      r_status;
    logic [2:0]      r_res_f;
    logic [9:0]      r_res_row, r_res_col;
    logic [IW-1:0]   r_hit_idx;
    logic [IW-1:0]   r_clr_addr;
    logic [2:0]      r_mem [DEPTH];
    logic [2:0]      r_rd;
    logic [SW-1:0]   r_cnt_s [MAX_FLOORS];
    logic [SW-1:0]   r_cnt_l [MAX_FLOORS];

    // Scan issue stage and check stage.
    logic            r_sc_run, r_sc_single;
    logic [3:0]      r_sc_g;
    logic [SW-1:0]   r_sc_a;
    logic [9:0]      r_sc_row, r_sc_col;
    logic [IW-1:0]   r_sc_idx;
    logic [IW:0]     r_sc_base;
    logic            r_pv;
    logic [3:0]      r_p_g;
    logic [9:0]      r_p_row, r_p_col;
    logic [IW-1:0]   r_p_idx;

    // Best-floor search.
    logic [3:0]      r_bg, r_best_f;
    logic [SW-1:0]   r_best;

    logic [21:0]     prod_span, prod_off;
    logic [31:0]     idx_full;
    logic [IW-1:0]   rd_addr;
    logic            hit, last_a;
    logic [SW-1:0]   cur_s, cur_l, best_v;
    logic            res_in_range;
    logic [IW:0]     next_base;
    logic [3:0]      start_f;

    assign prod_span = 22'(rows_eff) * 22'(cols_eff);
    assign prod_off  = 22'(r_item.row_index) * 22'(cols_eff) + 22'(r_item.column_index);
    assign idx_full  = 32'(r_item.floor_index) * SLOTS_PER_FLOOR + 32'(prod_off);
    assign rd_addr   = r_sc_run ? r_sc_idx : r_idx;
    assign hit       = r_pv && (r_rd[1:0] == r_item.slot_kind) && !r_rd[2];
    assign last_a    = (32'(r_sc_a) + 32'd1 == 32'(r_span));
    assign next_base = r_sc_base + (IW+1)'(SLOTS_PER_FLOOR);
    assign start_f   = i_cmd.scan_single ? r_best_f : 4'd0;

    assign res_in_range = (32'(r_res_f) < MAX_FLOORS);
    assign cur_s  = res_in_range ? r_cnt_s[fidx(4'(r_res_f))] : '0;
    assign cur_l  = res_in_range ? r_cnt_l[fidx(4'(r_res_f))] : '0;
    assign best_v = (r_item.slot_kind == KIND_SMALL) ? r_cnt_s[fidx(r_bg)]
                                                     : r_cnt_l[fidx(r_bg)];

    // Item capture, address arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item    <= i_item;
            r_res_f   <= i_item.floor_index;
            r_res_row <= (i_item.mode == MODE_ALLOC) ? 10'd0 : i_item.row_index;
            r_res_col <= (i_item.mode == MODE_ALLOC) ? 10'd0 : i_item.column_index;
        end
        if (i_cmd.prep) begin
            r_span <= (prod_span > 22'(SLOTS_PER_FLOOR)) ? SW'(SLOTS_PER_FLOOR)
                                                         : SW'(prod_span);
            r_off  <= prod_off;
            r_idx  <= IW'(idx_full);
        end
        if (i_cmd.set_st) r_status <= i_cmd.st_code;
        if (hit) begin
            r_res_f   <= r_p_g[2:0];
            r_res_row <= r_p_row;
            r_res_col <= r_p_col;
            r_hit_idx <= r_p_idx;
        end
    end

    // Slot memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (i_cmd.clear)           r_mem[r_clr_addr] <= 3'b000;
        else if (i_cmd.wr_load)    r_mem[r_idx] <= {1'b0, r_item.slot_kind};
        else if (i_cmd.wr_release) r_mem[r_idx] <= {1'b0, r_rd[1:0]};
        else if (i_cmd.wr_alloc)   r_mem[r_hit_idx] <= {1'b1, r_item.slot_kind};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_clr_addr <= '0;
        else if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
    end

    // Free counts per floor.
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] s, l;
        logic          old_free;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FLOORS; k++) begin
                r_cnt_s[k] <= '0;
                r_cnt_l[k] <= '0;
            end
        end else if (i_cmd.cnt_op != CNT_NONE) begin
            s = cur_s;
            l = cur_l;
            old_free = !r_rd[2];
            case (i_cmd.cnt_op)
                CNT_LOAD: begin
                    if (old_free && r_rd[1:0] == KIND_SMALL && s != '0) s = s - 1'b1;
                    if (old_free && r_rd[1:0] == KIND_LARGE && l != '0) l = l - 1'b1;
                    if (r_item.slot_kind == KIND_SMALL) s = s + 1'b1;
                    if (r_item.slot_kind == KIND_LARGE) l = l + 1'b1;
                end
                CNT_REL: begin
                    if (r_rd[1:0] == KIND_SMALL) s = s + 1'b1;
                    else                         l = l + 1'b1;
                end
                CNT_ALLOC: begin
                    if (r_item.slot_kind == KIND_SMALL && s != '0) s = s - 1'b1;
                    if (r_item.slot_kind == KIND_LARGE && l != '0) l = l - 1'b1;
                end
                default: ;
            endcase
            r_cnt_s[fidx(4'(r_res_f))] <= s;
            r_cnt_l[fidx(4'(r_res_f))] <= l;
        end
    end

    // Best-floor search, one floor a cycle; ties keep the lower floor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.best_start) begin
            r_bg     <= 4'd0;
            r_best   <= '0;
            r_best_f <= 4'd0;
        end else if (i_cmd.best_step) begin
            r_bg <= r_bg + 4'd1;
            if (best_v > r_best) begin
                r_best   <= best_v;
                r_best_f <= r_bg;
            end
        end
    end

    // Serial scan: issue one address a cycle, check the data in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_run <= 1'b0;
            r_pv     <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_sc_run    <= 1'b1;
            r_sc_single <= i_cmd.scan_single;
            r_sc_g      <= start_f;
            r_sc_base   <= (IW+1)'(32'(start_f) * SLOTS_PER_FLOOR);
            r_sc_idx    <= IW'(32'(start_f) * SLOTS_PER_FLOOR);
            r_sc_a      <= '0;
            r_sc_row    <= 10'd0;
            r_sc_col    <= 10'd0;
            r_pv        <= 1'b0;
        end else if (hit) begin
            r_sc_run <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_pv    <= r_sc_run;
            r_p_g   <= r_sc_g;
            r_p_row <= r_sc_row;
            r_p_col <= r_sc_col;
            r_p_idx <= r_sc_idx;
            if (r_sc_run) begin
                if (last_a) begin
                    if (r_sc_single || (r_sc_g + 4'd1 >= nf)) begin
                        r_sc_run <= 1'b0;
                    end else begin
                        r_sc_g    <= r_sc_g + 4'd1;
                        r_sc_base <= next_base;
                        r_sc_idx  <= IW'(next_base);
                        r_sc_a    <= '0;
                        r_sc_row  <= 10'd0;
                        r_sc_col  <= 10'd0;
                    end
                end else begin
                    r_sc_a   <= r_sc_a + 1'b1;
                    r_sc_idx <= r_sc_idx + 1'b1;
                    if (11'(r_sc_col) + 11'd1 == cols_eff) begin
                        r_sc_col <= 10'd0;
                        r_sc_row <= r_sc_row + 10'd1;
                    end else begin
                        r_sc_col <= r_sc_col + 10'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_sts.clear_last = (r_clr_addr == IW'(DEPTH - 1));
        o_sts.mode       = r_item.mode;
        o_sts.kind       = r_item.slot_kind;
        o_sts.strategy   = r_item.strategy;
        o_sts.exists     = (4'(r_item.floor_index) < nf)
                        && (11'(r_item.row_index) < rows_eff)
                        && (11'(r_item.column_index) < cols_eff)
                        && (r_off < 22'(SLOTS_PER_FLOOR));
        o_sts.slot_ok    = r_rd[2] && (r_rd[1:0] == KIND_SMALL || r_rd[1:0] == KIND_LARGE);
        o_sts.best_last  = (r_bg + 4'd1 >= nf);
        o_sts.best_zero  = (r_best == '0);
        o_sts.scan_hit   = hit;
        o_sts.scan_miss  = r_pv && !hit && !r_sc_run;
    end

    always_comb begin
        o_result.status         = r_status;
        o_result.granted_floor  = r_res_f;
        o_result.granted_row    = r_res_row;
        o_result.granted_column = r_res_col;
        o_result.free_small     = sat11(cur_s);
        o_result.free_large     = sat11(cur_l);
    end

endmodule
`default_nettype wire

// ----- design/typed_slot_allocator.sv -----
// Top level of the typed slot allocator: configuration registers on the
// APB-style port, and the controller and datapath. Depends on tsa_pkg,
// tsa_ctrl and tsa_datapath.
//
// Usage. A command word is taken on i_item at a rising edge where start is
// high and busy is low. Each word produces exactly one result word, shown on
// o_result for a single cycle while o_result_valid is high; the receiver
// cannot stall it and must take it in that cycle.
// Sequence. A load or release of an existing slot goes through the prep, check,
// read, update and response states after it is accepted, a word rejected by
// its checks from check straight to response. The first-fit policy scans the
// slot memory serially, one slot a cycle through its single read port, and
// visits up to floors times slots on a floor. The most-free policy first
// walks the active floors, one a cycle, then scans only the chosen floor.
// busy stays high until the result is out, so one word is in flight at a time.
// Reset. After reset the block sweeps the slot memory to inactive and
// unoccupied, one entry a cycle, through all MAX_FLOORS * SLOTS_PER_FLOOR
// entries (8192 by default) with busy held high. Free counts and configuration
// registers reset at once; configuration writes are taken during the sweep.
// Configuration should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module typed_slot_allocator #(
    parameter int MAX_FLOORS      = 8,
    parameter int SLOTS_PER_FLOOR = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  tsa_pkg::t_in_word  i_item,
    output logic               o_result_valid,
    output tsa_pkg::t_out_word o_result,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [3:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tsa_pkg::*;

    // Configuration registers, reset to one floor of 32 by 32 slots.
    logic [3:0]  r_floors;
    logic [10:0] r_rows;
    logic [10:0] r_cols;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floors <= 4'd1;
            r_rows   <= 11'd32;
            r_cols   <= 11'd32;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FLOORS:  r_floors <= pwdata[3:0];
                REG_ROWS:    r_rows   <= pwdata[10:0];
                REG_COLUMNS: r_cols   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Reads return the stored register value; unused addresses read zero.
    always_comb begin
        unique case (paddr[3:2])
            REG_FLOORS:  prdata = 32'(r_floors);
            REG_ROWS:    prdata = 32'(r_rows);
            REG_COLUMNS: prdata = 32'(r_cols);
            default:     prdata = 32'd0;
        endcase
    end

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller sequences each word; the datapath holds all slot and count storage.
    tsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_result_valid),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    tsa_datapath #(
        .MAX_FLOORS      (MAX_FLOORS),
        .SLOTS_PER_FLOOR (SLOTS_PER_FLOOR)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_floors (r_floors),
        .i_rows   (r_rows),
        .i_cols   (r_cols),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the typed slot allocator: drives command words,
// predicts each result word with an in-bench slot table and compares them.
// Depends on tsa_pkg and typed_slot_allocator.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import tsa_pkg::*;

    localparam int NUM_FLOORS = 8;
    localparam int FLOOR_SLOTS = 1024;
    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_item;
    logic        o_result_valid;
    t_out_word   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typed_slot_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predicted slot table, a mirror of what the block should hold.
    logic [1:0]  kind_mirror [NUM_FLOORS*FLOOR_SLOTS];
    logic        taken_mirror [NUM_FLOORS*FLOOR_SLOTS];
    int unsigned small_free [NUM_FLOORS];
    int unsigned large_free [NUM_FLOORS];
    int unsigned floors_reg, rows_reg, columns_reg;

    t_out_word   pending_words [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          use_gaps = 1;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clampv(int unsigned v, int unsigned lo,
                                           int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned eff_floors();
        return clampv(floors_reg, 1, NUM_FLOORS);
    endfunction
    function automatic int unsigned eff_rows();
        return clampv(rows_reg, 1, 1024);
    endfunction
    function automatic int unsigned eff_cols();
        return clampv(columns_reg, 1, 1024);
    endfunction

    function automatic bit slot_present(int unsigned f, int unsigned r, int unsigned c);
        if (f >= eff_floors() || r >= eff_rows() || c >= eff_cols()) return 0;
        return r * eff_cols() + c < FLOOR_SLOTS;
    endfunction

    function automatic t_out_word make_word(logic [1:0] st, int unsigned f,
                                            int unsigned r, int unsigned c);
        t_out_word w;
        int unsigned s, l;
        s = 0;
        l = 0;
        if (f < NUM_FLOORS) begin
            s = small_free[f];
            l = large_free[f];
        end
        w.status = st;
        w.granted_floor = f[2:0];
        w.granted_row = r[9:0];
        w.granted_column = c[9:0];
        w.free_small = s > 2047 ? 11'd2047 : s[10:0];
        w.free_large = l > 2047 ? 11'd2047 : l[10:0];
        return w;
    endfunction

    function automatic string word_text(t_out_word w);
        return $sformatf("st=%0d f=%0d r=%0d c=%0d s=%0d l=%0d",
                         w.status, w.granted_floor, w.granted_row,
                         w.granted_column, w.free_small, w.free_large);
    endfunction

    // First free slot of a kind on one floor, or FLOOR_SLOTS when none.
    function automatic int unsigned first_free(int unsigned f, logic [1:0] k);
        int unsigned n;
        int unsigned idx;
        n = eff_rows() * eff_cols();
        if (n > FLOOR_SLOTS) n = FLOOR_SLOTS;
        for (int unsigned a = 0; a < n; a++) begin
            idx = f * FLOOR_SLOTS + a;
            if (kind_mirror[idx] == k && !taken_mirror[idx]) return a;
        end
        return FLOOR_SLOTS;
    endfunction

    // Applies one command word to the mirror and returns the result word.
    function automatic t_out_word predict_slot_result(t_in_word w);
        int unsigned f, r, c, idx, a, gf, best, v;
        logic [1:0] k, old;
        f = w.floor_index;
        r = w.row_index;
        c = w.column_index;
        k = w.slot_kind;
        case (w.mode)
            MODE_LOAD: begin
                if (k == KIND_BAD) return make_word(ST_BAD_KIND, f, r, c);
                if (!slot_present(f, r, c)) return make_word(ST_BAD_SLOT, f, r, c);
                idx = f * FLOOR_SLOTS + r * eff_cols() + c;
                old = kind_mirror[idx];
                if (!taken_mirror[idx]) begin
                    if (old == KIND_SMALL && small_free[f] > 0) small_free[f]--;
                    if (old == KIND_LARGE && large_free[f] > 0) large_free[f]--;
                end
                kind_mirror[idx] = k;
                taken_mirror[idx] = 0;
                if (k == KIND_SMALL) small_free[f]++;
                if (k == KIND_LARGE) large_free[f]++;
                return make_word(ST_OK, f, r, c);
            end
            MODE_ALLOC: begin
                if (k != KIND_SMALL && k != KIND_LARGE)
                    return make_word(ST_BAD_KIND, f, 0, 0);
                a = FLOOR_SLOTS;
                gf = 0;
                if (!w.strategy) begin
                    for (int unsigned g = 0; g < eff_floors(); g++) begin
                        a = first_free(g, k);
                        if (a < FLOOR_SLOTS) begin
                            gf = g;
                            break;
                        end
                    end
                end else begin
                    best = 0;
                    for (int unsigned g = 0; g < eff_floors(); g++) begin
                        v = k == KIND_SMALL ? small_free[g] : large_free[g];
                        if (v > best) begin
                            best = v;
                            gf = g;
                        end
                    end
                    if (best > 0) a = first_free(gf, k);
                end
                if (a >= FLOOR_SLOTS) return make_word(ST_NO_FREE, f, 0, 0);
                taken_mirror[gf * FLOOR_SLOTS + a] = 1;
                if (k == KIND_SMALL && small_free[gf] > 0) small_free[gf]--;
                if (k == KIND_LARGE && large_free[gf] > 0) large_free[gf]--;
                return make_word(ST_OK, gf, a / eff_cols(), a % eff_cols());
            end
            MODE_RELEASE: begin
                if (!slot_present(f, r, c)) return make_word(ST_BAD_SLOT, f, r, c);
                idx = f * FLOOR_SLOTS + r * eff_cols() + c;
                old = kind_mirror[idx];
                if (!taken_mirror[idx] || (old != KIND_SMALL && old != KIND_LARGE))
                    return make_word(ST_BAD_SLOT, f, r, c);
                taken_mirror[idx] = 0;
                if (old == KIND_SMALL) small_free[f]++;
                else large_free[f]++;
                return make_word(ST_OK, f, r, c);
            end
            default: return make_word(ST_BAD_SLOT, f, r, c);
        endcase
    endfunction

    // Result checker: each strobed word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            t_out_word exp_w;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result word %h", o_result);
            end else begin
                exp_w = pending_words.pop_front();
                if (o_result !== exp_w) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %s, got %s",
                                 word_text(exp_w), word_text(o_result));
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("typed_slot_allocator verification failed");
            $finish;
        end
    end

    // Sends one command word; start stays high until the block takes it and
    // is dropped only by an idle burst or a drain.
    task automatic send_word(t_in_word w);
        if (use_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_words.insert(pending_words.size(), predict_slot_result(w));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One register write followed by a read back of the same register.
    task automatic write_reg(logic [1:0] index, int unsigned value);
        int unsigned expected;
        case (index)
            REG_FLOORS: expected = value & 32'hF;
            default: expected = value & 32'h7FF;
        endcase
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            REG_FLOORS: floors_reg = expected;
            REG_ROWS: rows_reg = expected;
            default: columns_reg = expected;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== expected) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Register %0d read back: expected %0d, got %0d",
                         index, expected, prdata);
        end
    endtask

    task automatic set_geometry(int unsigned f, int unsigned r, int unsigned c);
        drain_results();
        write_reg(REG_FLOORS, f);
        write_reg(REG_ROWS, r);
        write_reg(REG_COLUMNS, c);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_in_word make_cmd(logic [1:0] m, int unsigned f, int unsigned r,
                                          int unsigned c, logic [1:0] k, bit s);
        t_in_word w;
        w.mode = m;
        w.floor_index = f[2:0];
        w.row_index = r[9:0];
        w.column_index = c[9:0];
        w.slot_kind = k;
        w.strategy = s;
        return w;
    endfunction

    // Directed corner cases: field extremes, every mode and every error path.
    task automatic test_directed();
        set_geometry(8, 4, 4);
        send_word(make_cmd(MODE_ALLOC, 7, 0, 0, KIND_SMALL, 0));
        send_word(make_cmd(MODE_ALLOC, 3, 0, 0, KIND_INACTIVE, 0));
        send_word(make_cmd(MODE_ALLOC, 3, 0, 0, KIND_BAD, 1));
        send_word(make_cmd(MODE_LOAD, 0, 0, 0, KIND_BAD, 0));
        send_word(make_cmd(MODE_LOAD, 7, 1023, 1023, KIND_SMALL, 1));
        send_word(make_cmd(MODE_LOAD, 7, 3, 3, KIND_SMALL, 0));
        send_word(make_cmd(MODE_LOAD, 2, 0, 1, KIND_LARGE, 0));
        send_word(make_cmd(MODE_LOAD, 5, 2, 2, KIND_LARGE, 0));
        send_word(make_cmd(MODE_LOAD, 5, 2, 3, KIND_LARGE, 0));
        send_word(make_cmd(MODE_ALLOC, 0, 0, 0, KIND_LARGE, 0));
        send_word(make_cmd(MODE_ALLOC, 0, 0, 0, KIND_LARGE, 1));
        send_word(make_cmd(MODE_ALLOC, 6, 0, 0, KIND_SMALL, 1));
        send_word(make_cmd(MODE_ALLOC, 6, 0, 0, KIND_SMALL, 1));
        send_word(make_cmd(MODE_RELEASE, 7, 3, 3, KIND_INACTIVE, 0));
        send_word(make_cmd(MODE_RELEASE, 7, 3, 3, KIND_INACTIVE, 0));
        send_word(make_cmd(MODE_RELEASE, 1, 0, 0, KIND_SMALL, 0));
        send_word(make_cmd(MODE_RELEASE, 7, 1023, 0, KIND_SMALL, 0));
        send_word(make_cmd(MODE_ILLEGAL, 4, 1023, 1023, KIND_BAD, 1));
        send_word(make_cmd(MODE_LOAD, 5, 2, 2, KIND_INACTIVE, 0));
        // Geometry shrinks: the most-free floor may hold no slot in range.
        set_geometry(8, 1, 2);
        send_word(make_cmd(MODE_ALLOC, 0, 0, 0, KIND_LARGE, 1));
        send_word(make_cmd(MODE_LOAD, 3, 0, 1, KIND_SMALL, 0));
        send_word(make_cmd(MODE_ALLOC, 3, 0, 0, KIND_SMALL, 0));
    endtask

    // Random traffic on a geometry; mostly loads and allocations with some releases and a few illegal modes.
    task automatic test_random(int unsigned f, int unsigned r, int unsigned c, int n);
        t_in_word w;
        int unsigned pick;
        set_geometry(f, r, c);
        for (int i = 0; i < n; i++) begin
            w = 28'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) w.mode = MODE_LOAD;
            else if (pick < 70) w.mode = MODE_ALLOC;
            else if (pick < 95) w.mode = MODE_RELEASE;
            else w.mode = MODE_ILLEGAL;
            if ($urandom_range(0, 9) != 0) begin
                w.floor_index = 3'($urandom_range(0, clampv(f, 1, 8) - 1));
                w.row_index = 10'($urandom_range(0, clampv(r, 1, 1024) - 1));
                w.column_index = 10'($urandom_range(0, clampv(c, 1, 1024) - 1));
                if (w.mode != MODE_LOAD) w.slot_kind = 2'($urandom_range(1, 2));
            end
            send_word(w);
        end
    endtask

    // The sender holds off until every predicted word has come back.
    task automatic test_drain_pause();
        drain_results();
        send_word(make_cmd(MODE_ALLOC, 0, 0, 0, KIND_SMALL, 1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        floors_reg = 1;
        rows_reg = 32;
        columns_reg = 32;
        for (int i = 0; i < NUM_FLOORS * FLOOR_SLOTS; i++) begin
            kind_mirror[i] = KIND_INACTIVE;
            taken_mirror[i] = 1'b0;
        end
        for (int i = 0; i < NUM_FLOORS; i++) begin
            small_free[i] = 0;
            large_free[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The default geometry is exercised before any register write.
        send_word(make_cmd(MODE_LOAD, 0, 31, 31, KIND_LARGE, 0));
        send_word(make_cmd(MODE_ALLOC, 0, 0, 0, KIND_LARGE, 0));
        test_directed();
        test_random(2, 4, 8, 120);
        test_drain_pause();
        test_random(8, 1, 1, 100);
        test_random(1, 1, 1024, 60);
        test_random(3, 1024, 1, 60);
        test_random(15, 2047, 2047, 40);
        test_random(0, 0, 0, 40);
        test_random(8, 3, 5, 80);
        use_gaps = 0;
        test_random(4, 2, 6, 60);

        drain_results();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("typed_slot_allocator verification clean");
        else
            $display("typed_slot_allocator verification failed");
        $finish;
    end
endmodule
`default_nettype wire
